### rtl/uvs_pkg.sv
package uvs_pkg;

    localparam int SECTORS_DEF        = 36;
    localparam int STACKS_DEF         = 18;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    localparam int RADIUS_W = 16;
    localparam int RING_W   = 18;
    localparam int COORD_W  = 17;
    localparam int CORNER_W = 10;
    localparam int STEP_W   = 3;

    localparam int OUT_BITS    = 3 * COORD_W + 3 * CORNER_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W  = 8;

    // multiplier a operand
    localparam logic A_RADIUS = 1'b0;
    localparam logic A_RING   = 1'b1;

    // multiplier b operand
    localparam logic [1:0] B_SSIN = 2'd0;
    localparam logic [1:0] B_SCOS = 2'd1;
    localparam logic [1:0] B_CCOS = 2'd2;
    localparam logic [1:0] B_CSIN = 2'd3;

    // write-back targets
    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_RR   = 2'd1;
    localparam logic [1:0] WB_RH   = 2'd2;
    localparam logic [1:0] WB_X    = 2'd3;

    // sequencing
    localparam logic [1:0] J_NEXT     = 2'd0;
    localparam logic [1:0] J_GOTO     = 2'd1;
    localparam logic [1:0] J_DISPATCH = 2'd2;
    localparam logic [1:0] J_END      = 2'd3;

    typedef struct packed {
        logic              mul_en;
        logic              a_sel;
        logic [1:0]        b_sel;
        logic [1:0]        wb;
        logic [1:0]        jmp;
        logic [STEP_W-1:0] target;
        logic              emit_vtx;
        logic              emit_tri;
    } ctrl_t;

    typedef struct packed {
        logic tri_phase;
        logic sector_nz;
        logic out_free;
    } seq_cond_t;

endpackage

### rtl/uv_sphere_mesh_generator.sv
// uv sphere mesh generator, one mesh element per input transaction
// vertex: steps DISP, VX, XW, OUT; DISP, RH, RX, XW, OUT on the first vertex of a ring
// triangle: steps DISP, TRI; the last step writes the result register
// a new transaction is taken in the last step of the previous one; one shared multiplier
// and the microcode program set the step count
// asynchronous active-low reset: radius 256, sequencer idle, mesh restarts at vertex 0
module uv_sphere_mesh_generator
    import uvs_pkg::*;
#(
    parameter int SECTORS        = SECTORS_DEF,
    parameter int STACKS         = STACKS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [RADIUS_W-1:0]    cfg_data,       // sphere_radius

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // restart, zero pad

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // coord_x, coord_y, coord_z,
                                                   // corner_a, corner_b, corner_c, zero pad
    output logic                   m_axis_tuser,   // element_kind
    output logic                   m_axis_tlast    // mesh_end
);

    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int PW    = RING_W + TW;
    localparam int STK_W = $clog2(STACKS + 1);
    localparam int SEC_W = $clog2(SECTORS + 1);
    localparam int IW    = $clog2((STACKS + 1) * (SECTORS + 1));
    localparam int IXW   = (IW > CORNER_W) ? IW : CORNER_W;
    localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << (TRIG_FRAC_BITS - 1));

    logic [RADIUS_W-1:0]    radius_reg;
    logic                   phase_reg;
    logic                   phase_next;
    logic [STK_W-1:0]       stack_reg;
    logic [STK_W-1:0]       stack_next;
    logic [SEC_W-1:0]       sector_reg;
    logic [SEC_W-1:0]       sector_next;
    logic                   second_reg;
    logic                   second_next;
    logic signed [RING_W-1:0] ring_r_reg;
    logic signed [RING_W-1:0] ring_r_next;
    logic signed [RING_W-1:0] ring_h_reg;
    logic signed [RING_W-1:0] ring_h_next;
    logic signed [RING_W-1:0] x_reg;
    logic signed [RING_W-1:0] x_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   prod_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_kind_reg;
    logic                   out_kind_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic [COORD_W-1:0]     out_x_reg;
    logic [COORD_W-1:0]     out_x_next;
    logic [COORD_W-1:0]     out_y_reg;
    logic [COORD_W-1:0]     out_y_next;
    logic [COORD_W-1:0]     out_z_reg;
    logic [COORD_W-1:0]     out_z_next;
    logic [CORNER_W-1:0]    out_a_reg;
    logic [CORNER_W-1:0]    out_a_next;
    logic [CORNER_W-1:0]    out_b_reg;
    logic [CORNER_W-1:0]    out_b_next;
    logic [CORNER_W-1:0]    out_c_reg;
    logic [CORNER_W-1:0]    out_c_next;

    ctrl_t                  ctrl;
    seq_cond_t              cond;
    logic                   accept;
    logic                   seq_ready;
    logic signed [TW-1:0]   stack_sin;
    logic signed [TW-1:0]   stack_cos;
    logic signed [TW-1:0]   sector_sin;
    logic signed [TW-1:0]   sector_cos;
    logic signed [RING_W-1:0] mul_a;
    logic signed [TW-1:0]   mul_b;
    logic signed [PW-1:0]   rnd_full;
    logic signed [RING_W-1:0] rnd_val;
    logic [IXW-1:0]         k1;
    logic [IXW-1:0]         k2;
    logic [IXW-1:0]         k1_inc;
    logic [IXW-1:0]         k2_inc;
    logic [SEC_W-1:0]       sec_inc;
    logic [STK_W-1:0]       stk_new;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = seq_ready;
    assign accept        = s_axis_tvalid && seq_ready;

    assign cond.tri_phase = phase_reg;
    assign cond.sector_nz = (sector_reg != '0);
    assign cond.out_free  = !out_valid_reg || m_axis_tready;

    uvs_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .cond  (cond),
        .ready (seq_ready),
        .ctrl  (ctrl)
    );

    uvs_trig_rom #(
        .SECTORS        (SECTORS),
        .STACKS         (STACKS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .stack_idx  (stack_reg),
        .sector_idx (sector_reg),
        .stack_sin  (stack_sin),
        .stack_cos  (stack_cos),
        .sector_sin (sector_sin),
        .sector_cos (sector_cos)
    );

    always_comb
    begin
        mul_a = (ctrl.a_sel == A_RING) ? ring_r_reg : signed'({2'b00, radius_reg});
        case (ctrl.b_sel)
            B_SSIN:  mul_b = stack_sin;
            B_SCOS:  mul_b = stack_cos;
            B_CCOS:  mul_b = sector_cos;
            B_CSIN:  mul_b = sector_sin;
            default: mul_b = '0;
        endcase
    end

    // round to nearest, ties up
    assign rnd_full = (prod_reg + RND_HALF) >>> TRIG_FRAC_BITS;
    assign rnd_val  = rnd_full[RING_W-1:0];

    assign k1      = IXW'(stack_reg) * IXW'(SECTORS + 1) + IXW'(sector_reg);
    assign k2      = k1 + IXW'(SECTORS + 1);
    assign k1_inc  = k1 + 1'b1;
    assign k2_inc  = k2 + 1'b1;
    assign sec_inc = sector_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        stack_next     = stack_reg;
        sector_next    = sector_reg;
        second_next    = second_reg;
        ring_r_next    = ring_r_reg;
        ring_h_next    = ring_h_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_c_next     = out_c_reg;
        stk_new        = stack_reg;

        if (ctrl.mul_en)
        begin
            prod_next = PW'(mul_a) * PW'(mul_b);
        end

        case (ctrl.wb)
            WB_RR:   ring_r_next = rnd_val;
            WB_RH:   ring_h_next = rnd_val;
            WB_X:    x_next      = rnd_val;
            default: ;
        endcase

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.emit_vtx)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = 1'b0;
            out_last_next  = 1'b0;
            out_x_next     = x_reg[COORD_W-1:0];
            out_y_next     = rnd_val[COORD_W-1:0];
            out_z_next     = ring_h_reg[COORD_W-1:0];
            out_a_next     = '0;
            out_b_next     = '0;
            out_c_next     = '0;
            if (sector_reg == SEC_W'(SECTORS))
            begin
                sector_next = '0;
                if (stack_reg == STK_W'(STACKS))
                begin
                    phase_next  = 1'b1;
                    stack_next  = '0;
                    second_next = 1'b1;
                end
                else
                begin
                    stack_next = stack_reg + 1'b1;
                end
            end
            else
            begin
                sector_next = sec_inc;
            end
        end

        if (ctrl.emit_tri)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = 1'b1;
            out_last_next  = 1'b0;
            out_x_next     = '0;
            out_y_next     = '0;
            out_z_next     = '0;
            out_b_next     = k2[CORNER_W-1:0];
            if (!second_reg)
            begin
                out_a_next = k1[CORNER_W-1:0];
                out_c_next = k1_inc[CORNER_W-1:0];
            end
            else
            begin
                out_a_next = k1_inc[CORNER_W-1:0];
                out_c_next = k2_inc[CORNER_W-1:0];
            end
            if (!second_reg && stack_reg != STK_W'(STACKS - 1))
            begin
                second_next = 1'b1;
            end
            else
            begin
                if (sec_inc >= SEC_W'(SECTORS))
                begin
                    sector_next = '0;
                    stk_new     = stack_reg + 1'b1;
                end
                else
                begin
                    sector_next = sec_inc;
                end
                stack_next  = stk_new;
                second_next = (stk_new == '0);
                if (stk_new >= STK_W'(STACKS))
                begin
                    out_last_next = 1'b1;
                    phase_next    = 1'b0;
                    stack_next    = '0;
                    sector_next   = '0;
                    second_next   = 1'b0;
                end
            end
        end

        // restart wins over the update of the element just finished
        if (accept && s_axis_tdata[0])
        begin
            phase_next  = 1'b0;
            stack_next  = '0;
            sector_next = '0;
            second_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_W'(256);
            phase_reg     <= 1'b0;
            stack_reg     <= '0;
            sector_reg    <= '0;
            second_reg    <= 1'b0;
            ring_r_reg    <= '0;
            ring_h_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                radius_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            stack_reg     <= stack_next;
            sector_reg    <= sector_next;
            second_reg    <= second_next;
            ring_r_reg    <= ring_r_next;
            ring_h_reg    <= ring_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_c_reg    <= out_c_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_c_reg, out_b_reg, out_a_reg,
                                         out_z_reg, out_y_reg, out_x_reg});

endmodule

### rtl/uvs_trig_rom.sv
module uvs_trig_rom
    import uvs_pkg::*;
#(
    parameter int SECTORS        = SECTORS_DEF,
    parameter int STACKS         = STACKS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int TW            = TRIG_FRAC_BITS + 2,
    localparam int STK_W         = $clog2(STACKS + 1),
    localparam int SEC_W         = $clog2(SECTORS + 1)
)
(
    input  logic [STK_W-1:0]     stack_idx,
    input  logic [SEC_W-1:0]     sector_idx,
    output logic signed [TW-1:0] stack_sin,
    output logic signed [TW-1:0] stack_cos,
    output logic signed [TW-1:0] sector_sin,
    output logic signed [TW-1:0] sector_cos
);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // taylor series of sine in q2.30, argument in 0..pi/2
    function automatic longint unsigned sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd420;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        return longint'(sum);
    endfunction

    function automatic logic signed [TW-1:0] trig_finish(input longint unsigned mag_q30,
                                                         input logic neg);
        longint unsigned mag;
        longint          val;
        mag = (mag_q30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (mag > (64'd1 << TRIG_FRAC_BITS))
        begin
            mag = 64'd1 << TRIG_FRAC_BITS;
        end
        val = longint'(mag);
        if (neg)
        begin
            val = -val;
        end
        return TW'(val);
    endfunction

    // sine of (pi/2)*m/STACKS
    function automatic logic signed [TW-1:0] stack_trig(input int unsigned m);
        int unsigned     q;
        int unsigned     r;
        longint unsigned x;
        q = (m / STACKS) & 3;
        r = m % STACKS;
        if (q[0])
        begin
            r = STACKS - r;
        end
        x = (HALF_PI_Q30 * 64'(r)) / STACKS;
        return trig_finish(sin_q30(x), q >= 2);
    endfunction

    // sine of (pi/2)*m/SECTORS
    function automatic logic signed [TW-1:0] sector_trig(input int unsigned m);
        int unsigned     q;
        int unsigned     r;
        longint unsigned x;
        q = (m / SECTORS) & 3;
        r = m % SECTORS;
        if (q[0])
        begin
            r = SECTORS - r;
        end
        x = (HALF_PI_Q30 * 64'(r)) / SECTORS;
        return trig_finish(sin_q30(x), q >= 2);
    endfunction

    logic signed [TW-1:0] ssin_tab [0:STACKS];
    logic signed [TW-1:0] scos_tab [0:STACKS];
    logic signed [TW-1:0] csin_tab [0:SECTORS];
    logic signed [TW-1:0] ccos_tab [0:SECTORS];

    for (genvar g = 0; g <= STACKS; g++)
    begin : g_stack
        localparam logic signed [TW-1:0] SIN_V = stack_trig(2 * g);
        localparam logic signed [TW-1:0] COS_V = stack_trig(2 * g + STACKS);
        assign ssin_tab[g] = SIN_V;
        assign scos_tab[g] = COS_V;
    end

    for (genvar g = 0; g <= SECTORS; g++)
    begin : g_sector
        localparam logic signed [TW-1:0] SIN_V = sector_trig(4 * g);
        localparam logic signed [TW-1:0] COS_V = sector_trig(4 * g + SECTORS);
        assign csin_tab[g] = SIN_V;
        assign ccos_tab[g] = COS_V;
    end

    always_comb
    begin
        stack_sin = '0;
        stack_cos = '0;
        if (stack_idx <= STK_W'(STACKS))
        begin
            stack_sin = ssin_tab[stack_idx];
            stack_cos = scos_tab[stack_idx];
        end
    end

    always_comb
    begin
        sector_sin = '0;
        sector_cos = '0;
        if (sector_idx <= SEC_W'(SECTORS))
        begin
            sector_sin = csin_tab[sector_idx];
            sector_cos = ccos_tab[sector_idx];
        end
    end

endmodule

### rtl/uvs_sequencer.sv
module uvs_sequencer
    import uvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  seq_cond_t cond,
    output logic      ready,
    output ctrl_t     ctrl
);

    localparam logic [STEP_W-1:0] STEP_DISP = 3'd0;
    localparam logic [STEP_W-1:0] STEP_RH   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_RX   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_XW   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_OUT  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_VX   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_TRI  = 3'd6;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_t             word;
    logic              hold;

    // program: mul_en a_sel b_sel wb jmp target emit_vtx emit_tri
    always_comb
    begin
        case (step_reg)
            STEP_DISP: word = '{1'b1, A_RADIUS, B_SSIN, WB_NONE, J_DISPATCH, STEP_DISP,
                                1'b0, 1'b0};
            STEP_RH:   word = '{1'b1, A_RADIUS, B_SCOS, WB_RR, J_NEXT, STEP_DISP,
                                1'b0, 1'b0};
            STEP_RX:   word = '{1'b1, A_RING, B_CCOS, WB_RH, J_NEXT, STEP_DISP,
                                1'b0, 1'b0};
            STEP_XW:   word = '{1'b1, A_RING, B_CSIN, WB_X, J_NEXT, STEP_DISP,
                                1'b0, 1'b0};
            STEP_OUT:  word = '{1'b0, A_RADIUS, B_SSIN, WB_NONE, J_END, STEP_DISP,
                                1'b1, 1'b0};
            STEP_VX:   word = '{1'b1, A_RING, B_CCOS, WB_NONE, J_GOTO, STEP_XW,
                                1'b0, 1'b0};
            STEP_TRI:  word = '{1'b0, A_RADIUS, B_SSIN, WB_NONE, J_END, STEP_DISP,
                                1'b0, 1'b1};
            default:   word = '{1'b0, A_RADIUS, B_SSIN, WB_NONE, J_END, STEP_DISP,
                                1'b0, 1'b0};
        endcase
    end

    assign hold  = (word.emit_vtx || word.emit_tri) && !cond.out_free;
    assign ready = !busy_reg || (word.jmp == J_END && !hold);

    always_comb
    begin
        ctrl = '0;
        if (busy_reg)
        begin
            ctrl          = word;
            ctrl.emit_vtx = word.emit_vtx && cond.out_free;
            ctrl.emit_tri = word.emit_tri && cond.out_free;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = STEP_DISP;
            end
        end
        else if (!hold)
        begin
            case (word.jmp)
                J_NEXT:
                begin
                    step_next = step_reg + 1'b1;
                end
                J_GOTO:
                begin
                    step_next = word.target;
                end
                J_DISPATCH:
                begin
                    if (cond.tri_phase)
                    begin
                        step_next = STEP_TRI;
                    end
                    else if (cond.sector_nz)
                    begin
                        step_next = STEP_VX;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                J_END:
                begin
                    busy_next = start;
                    step_next = STEP_DISP;
                end
                default:
                begin
                    busy_next = 1'b0;
                    step_next = STEP_DISP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_DISP;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule
